// ----- rtl/c_string_escaper_macros.svh -----
// assertion helpers shared by the escaper rtl
`ifndef C_STRING_ESCAPER_MACROS_SVH
`define C_STRING_ESCAPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cse_pkg.sv -----
`timescale 1ns / 1ps

package cse_pkg;

  // queue between classifier and serializer, depth kept a power of two
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] FirstPrint  = 8'd32;
  localparam logic [7:0] LastPrint   = 8'd126;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChHexAlpha  = 8'h57;  // 'a' - 10

  // control codes with a one-character escape
  localparam logic [7:0] CcNul = 8'd0;
  localparam logic [7:0] CcBel = 8'd7;
  localparam logic [7:0] CcBs  = 8'd8;
  localparam logic [7:0] CcTab = 8'd9;
  localparam logic [7:0] CcLf  = 8'd10;
  localparam logic [7:0] CcVt  = 8'd11;
  localparam logic [7:0] CcFf  = 8'd12;
  localparam logic [7:0] CcCr  = 8'd13;

  localparam logic [7:0] LtA = 8'h61;
  localparam logic [7:0] LtB = 8'h62;
  localparam logic [7:0] LtF = 8'h66;
  localparam logic [7:0] LtN = 8'h6E;
  localparam logic [7:0] LtR = 8'h72;
  localparam logic [7:0] LtT = 8'h74;
  localparam logic [7:0] LtV = 8'h76;

  typedef enum logic [1:0] {
    EscPlain = 2'd0,  // byte as is
    EscPair  = 2'd1,  // backslash + payload
    EscHex   = 2'd2   // backslash, x, two hex digits of payload
  } cse_kind_e;

  typedef struct packed {
    cse_kind_e   kind;
    logic [7:0]  payload;
    logic        str_end;
  } cse_entry_t;

  typedef struct packed {
    logic        valid;
    cse_entry_t  entry;
  } cse_head_t;

  function automatic cse_entry_t classify(logic [7:0] b, logic str_end);
    cse_entry_t e;
    e.str_end = str_end;
    e.payload = b;
    e.kind    = EscHex;
    if (b >= FirstPrint && b <= LastPrint) begin
      if (b == ChDquote || b == ChBackslash) begin
        e.kind = EscPair;
      end else begin
        e.kind = EscPlain;
      end
    end else begin
      unique case (b)
        CcBel: begin e.kind = EscPair; e.payload = LtA; end
        CcBs:  begin e.kind = EscPair; e.payload = LtB; end
        CcFf:  begin e.kind = EscPair; e.payload = LtF; end
        CcLf:  begin e.kind = EscPair; e.payload = LtN; end
        CcCr:  begin e.kind = EscPair; e.payload = LtR; end
        CcTab: begin e.kind = EscPair; e.payload = LtT; end
        CcVt:  begin e.kind = EscPair; e.payload = LtV; end
        CcNul: begin e.kind = EscPair; e.payload = ChZero; end
        default: e.kind = EscHex;
      endcase
    end
    return e;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) begin
      return ChZero + {4'h0, n};
    end
    return ChHexAlpha + {4'h0, n};
  endfunction

  // index of the final output byte for each kind
  function automatic logic [1:0] last_idx(cse_kind_e k);
    logic [1:0] r;
    unique case (k)
      EscPlain: r = 2'd0;
      EscPair:  r = 2'd1;
      EscHex:   r = 2'd3;
      default:  r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/cse_if.sv -----
`timescale 1ns / 1ps

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_string_end;

  modport source (output valid, output in_byte, output in_string_end, input ready);
  modport sink   (input valid, input in_byte, input in_string_end, output ready);
endinterface

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       out_string_end;

  modport source (output valid, output out_byte, output run_last, output out_string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input out_string_end,
                  output ready);
endinterface

// ----- rtl/cse_front.sv -----
`timescale 1ns / 1ps

module cse_front (
  cse_in_if.sink              in_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output cse_pkg::cse_entry_t entry_o
);

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;
  assign entry_o    = cse_pkg::classify(in_i.in_byte, in_i.in_string_end);

endmodule

// ----- rtl/cse_queue.sv -----
`timescale 1ns / 1ps
`include "c_string_escaper_macros.svh"

module cse_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cse_pkg::cse_entry_t entry_i,
  output logic                push_ready_o,
  output cse_pkg::cse_head_t  head_o,
  input  logic                pop_i
);

  cse_pkg::cse_entry_t              mem_q [cse_pkg::QDepth];
  logic [cse_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [cse_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [cse_pkg::QCntW-1:0]        cnt_q, cnt_d;

  assign push_ready_o = cnt_q != cse_pkg::QCntW'(cse_pkg::QDepth);
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + cse_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + cse_pkg::QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + cse_pkg::QCntW'(push_i) - cse_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `CSE_ASSERT_IMP(a_push_room, push_i, cnt_q != cse_pkg::QCntW'(cse_pkg::QDepth), "push into full queue")
  `CSE_ASSERT_IMP(a_pop_avail, pop_i, cnt_q != '0, "pop from empty queue")

endmodule

// ----- rtl/cse_back.sv -----
`timescale 1ns / 1ps
`include "c_string_escaper_macros.svh"

module cse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cse_pkg::cse_head_t head_i,
  output logic               pop_o,
  cse_out_if.source          out_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_run_last_q;
  logic       out_str_end_q;

  logic       load;
  logic       is_last;
  logic [7:0] sym;

  assign load    = head_i.valid && (!out_valid_q || out_o.ready);
  assign is_last = idx_q == cse_pkg::last_idx(head_i.entry.kind);
  assign pop_o   = load && is_last;

  // byte at the current position of the escape sequence
  always_comb begin
    case (idx_q)
      2'd0: sym = (head_i.entry.kind == cse_pkg::EscPlain) ? head_i.entry.payload
                                                           : cse_pkg::ChBackslash;
      2'd1: sym = (head_i.entry.kind == cse_pkg::EscHex) ? cse_pkg::ChLowerX
                                                         : head_i.entry.payload;
      2'd2: sym = cse_pkg::hex_digit(head_i.entry.payload[7:4]);
      2'd3: sym = cse_pkg::hex_digit(head_i.entry.payload[3:0]);
      default: sym = cse_pkg::ChBackslash;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q     <= sym;
      out_run_last_q <= is_last;
      out_str_end_q  <= is_last && head_i.entry.str_end;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.run_last       = out_run_last_q;
  assign out_o.out_string_end = out_str_end_q;

  `CSE_ASSERT_IMP(a_mid_seq_head, idx_q != 2'd0, head_i.valid, "head lost mid sequence")
  `CSE_ASSERT_IMP(a_end_on_last, out_valid_q && out_str_end_q, out_run_last_q, "string end off last")
  `CSE_ASSERT_NXT(a_pop_rewinds, pop_o, idx_q == 2'd0, "index not rewound after pop")

endmodule

// ----- rtl/c_string_escaper.sv -----
`timescale 1ns / 1ps
// an accepted byte is queued, then its first escaped beat is registered as output
// throughput: one output beat per cycle while the sink is ready; each input byte
//   becomes 1, 2 or 4 beats, which the back-end serializer walks one byte a cycle
// input is taken while the back end drains, up to a 4-entry queue
// reset: rst_ni async active low, empties the queue and drops any pending beat

module c_string_escaper (
  input  logic      clk_i,
  input  logic      rst_ni,
  cse_in_if.sink    in_i,
  cse_out_if.source out_o
);

  // front: classify each raw byte into plain, two-byte escape or hex escape
  logic                q_ready;
  logic                push;
  cse_pkg::cse_entry_t entry;

  // back: head of the queue and pop strobe
  cse_pkg::cse_head_t  head;
  logic                pop;

  cse_front u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (entry)
  );

  // decouples the classifier from the serializer so a stalled output
  // does not stop the input until the queue fills
  cse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .push_ready_o (q_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // serializer with a registered output beat; the entry leaves the queue
  // together with its last beat
  cse_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ----- dv/c_string_escaper_tb.sv -----
`timescale 1ns / 1ps

module c_string_escaper_tb;

  // one escaped output beat as the sink sees it
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } esc_beat_t;

  // directed row: escaped text typed in where it is obvious, else zero beats
  // and the predictor supplies the answer
  typedef struct packed {
    logic [7:0]  raw;
    logic        str_end;
    logic [2:0]  n_typed;
    logic [31:0] escaped;  // typed beats, first beat in the highest used byte
  } directed_row_t;

  localparam int    HoldCycles  = 120;   // long sink hold-off
  localparam int    IdleLimit   = 1000;  // cycles without any beat moving
  localparam int    DrainCycles = 10;
  localparam string HexText     = "0123456789abcdef";

  localparam logic [7:0] CtrlCodes [8] = '{
    cse_pkg::CcBel, cse_pkg::CcBs, cse_pkg::CcFf, cse_pkg::CcLf,
    cse_pkg::CcCr, cse_pkg::CcTab, cse_pkg::CcVt, cse_pkg::CcNul
  };

  localparam directed_row_t DirectedBytes [22] = '{
    '{8'h00,                1'b0, 3'd2, "\\0"},    // nul, lowest byte
    '{8'hFF,                1'b1, 3'd4, "\\xff"},  // highest byte, ends a string
    '{8'h20,                1'b0, 3'd1, " "},      // first printable
    '{8'h7E,                1'b1, 3'd1, "~"},      // last printable
    '{8'h7F,                1'b0, 3'd4, "\\x7f"},  // just past printable
    '{8'h1F,                1'b0, 3'd4, "\\x1f"},  // just below printable
    '{cse_pkg::ChDquote,    1'b0, 3'd2, "\\\""},
    '{cse_pkg::ChBackslash, 1'b1, 3'd2, "\\\\"},
    '{cse_pkg::CcBel,       1'b0, 3'd2, "\\a"},
    '{cse_pkg::CcBs,        1'b0, 3'd2, "\\b"},
    '{cse_pkg::CcTab,       1'b0, 3'd2, "\\t"},
    '{cse_pkg::CcLf,        1'b0, 3'd2, "\\n"},
    '{cse_pkg::CcVt,        1'b0, 3'd2, "\\v"},
    '{cse_pkg::CcFf,        1'b0, 3'd2, "\\f"},
    '{cse_pkg::CcCr,        1'b1, 3'd2, "\\r"},
    '{8'h01,                1'b0, 3'd0, 32'h0},
    '{8'h0E,                1'b0, 3'd0, 32'h0},
    '{8'h21,                1'b0, 3'd0, 32'h0},
    '{8'h5B,                1'b0, 3'd0, 32'h0},
    '{8'h80,                1'b1, 3'd0, 32'h0},
    '{8'hAA,                1'b0, 3'd0, 32'h0},
    '{8'h55,                1'b1, 3'd0, 32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  cse_in_if  in_if ();
  cse_out_if out_if ();

  c_string_escaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  esc_beat_t expected_beats [$];

  int  n_errors      = 0;
  int  n_bytes       = 0;
  int  n_beats       = 0;
  int  n_strings     = 0;
  int  n_holds       = 0;
  int  n_pauses      = 0;
  int  idle_cycles   = 0;
  bit  src_gaps_en   = 1'b1;
  bit  snk_gaps_en   = 1'b1;
  bit  hold_off_req  = 1'b0;

  // append one beat to the tail of the expected beats
  function automatic void expect_beat(input logic [7:0] data, input logic run_last,
                                      input logic str_end);
    esc_beat_t beat;
    beat = '{data, run_last, str_end};
    expected_beats.insert(expected_beats.size(), beat);
  endfunction

  // escaped form of one raw byte, appended to the expected beats
  function automatic void predict_escape(input logic [7:0] b, input logic str_end);
    logic [7:0]         seq [4];
    cse_pkg::cse_kind_e kind;
    int                 n;
    seq[0] = cse_pkg::ChBackslash;
    seq[1] = b;
    seq[2] = 8'h00;
    seq[3] = 8'h00;
    if (b >= cse_pkg::FirstPrint && b <= cse_pkg::LastPrint) begin
      // quote and backslash keep their char behind a backslash
      kind = (b == cse_pkg::ChDquote || b == cse_pkg::ChBackslash) ? cse_pkg::EscPair
                                                                    : cse_pkg::EscPlain;
      if (kind == cse_pkg::EscPlain) seq[0] = b;
    end else begin
      kind = cse_pkg::EscPair;
      case (b)
        cse_pkg::CcBel: seq[1] = cse_pkg::LtA;
        cse_pkg::CcBs:  seq[1] = cse_pkg::LtB;
        cse_pkg::CcFf:  seq[1] = cse_pkg::LtF;
        cse_pkg::CcLf:  seq[1] = cse_pkg::LtN;
        cse_pkg::CcCr:  seq[1] = cse_pkg::LtR;
        cse_pkg::CcTab: seq[1] = cse_pkg::LtT;
        cse_pkg::CcVt:  seq[1] = cse_pkg::LtV;
        cse_pkg::CcNul: seq[1] = cse_pkg::ChZero;
        default:        kind = cse_pkg::EscHex;
      endcase
    end
    if (kind == cse_pkg::EscHex) begin
      seq[1] = cse_pkg::ChLowerX;
      seq[2] = HexText[b[7:4]];
      seq[3] = HexText[b[3:0]];
    end
    n = (kind == cse_pkg::EscPlain) ? 1 : (kind == cse_pkg::EscPair) ? 2 : 4;
    for (int k = 0; k < n; k++) begin
      expect_beat(seq[k], k == n - 1, (k == n - 1) && str_end);
    end
  endfunction

  // byte mix that hits every escape class often, plus plain uniform bytes
  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0:       b = 8'($urandom_range(32, 126));
      1:       b = $urandom_range(0, 1) ? cse_pkg::ChDquote : cse_pkg::ChBackslash;
      2:       b = CtrlCodes[$urandom_range(0, 7)];
      3:       b = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                        : 8'($urandom_range(127, 255));
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // drive one byte, return at the edge where it is taken
  task automatic send_byte(input logic [7:0] b, input logic str_end);
    int gap;
    gap = src_gaps_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= b;
    in_if.in_string_end <= str_end;
    do @(posedge clk_i); while (!in_if.ready);
    n_bytes++;
    if (str_end) n_strings++;
  endtask

  task automatic send_random(input int count);
    logic [7:0] b;
    logic       str_end;
    for (int i = 0; i < count; i++) begin
      b       = random_byte();
      str_end = ($urandom_range(0, 7) == 0);
      send_byte(b, str_end);
      predict_escape(b, str_end);
    end
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // stimulus: directed table, then random strings under varying back-pressure
  initial begin
    directed_row_t row;
    int            n;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.in_byte        <= 8'h00;
    in_if.in_string_end  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedBytes[i]) begin
      row = DirectedBytes[i];
      send_byte(row.raw, row.str_end);
      if (row.n_typed == 0) begin
        predict_escape(row.raw, row.str_end);
      end else begin
        n = row.n_typed;
        for (int k = 0; k < n; k++) begin
          expect_beat(row.escaped[8 * (n - 1 - k) +: 8], k == n - 1,
                      (k == n - 1) && row.str_end);
        end
      end
    end

    // random gaps on both sides
    send_random(120);

    // back to back, no gaps anywhere
    src_gaps_en = 1'b0;
    snk_gaps_en = 1'b0;
    send_random(60);

    // sink holds off for a long stretch while the source keeps pushing,
    // so the queue fills and ready drops
    hold_off_req = 1'b1;
    send_random(30);

    // source stops until every escaped beat is out
    in_if.valid <= 1'b0;
    wait_drained();
    n_pauses++;

    src_gaps_en = 1'b1;
    snk_gaps_en = 1'b1;
    send_random(100);

    // gaps on one side only
    snk_gaps_en = 1'b0;
    send_random(40);
    src_gaps_en = 1'b0;
    snk_gaps_en = 1'b1;
    send_random(40);

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d escaped beats never arrived", $time, expected_beats.size());
      n_errors++;
    end

    $display("covered %0d raw bytes in %0d strings, %0d escaped beats checked",
             n_bytes, n_strings, n_beats);
    $display("with %0d long sink hold-off(s) and %0d source pause(s) until drained",
             n_holds, n_pauses);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // sink: random or long hold-offs, then check each beat against the oldest expectation
  initial begin
    esc_beat_t got;
    esc_beat_t want;
    int        gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = snk_gaps_en ? $urandom_range(0, 7) : 0;
      if (hold_off_req) begin
        gap          = HoldCycles;
        hold_off_req = 1'b0;
        n_holds++;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = '{out_if.out_byte, out_if.run_last, out_if.out_string_end};
      n_beats++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat byte=%02h run_last=%0b string_end=%0b",
                 $time, got.data, got.run_last, got.str_end);
        n_errors++;
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, got.data);
          n_errors++;
        end
        if (got.run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b actual %0b", $time, want.run_last,
                   got.run_last);
          n_errors++;
        end
        if (got.str_end !== want.str_end) begin
          $display("%0t: out_string_end expected %0b actual %0b", $time, want.str_end,
                   got.str_end);
          n_errors++;
        end
      end
    end
  end

  // watchdog: too long with no beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: timeout, %0d escaped beats still expected", $time,
                 expected_beats.size());
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- c_string_escaper.f -----
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_if.sv
rtl/cse_front.sv
rtl/cse_queue.sv
rtl/cse_back.sv
rtl/c_string_escaper.sv
dv/c_string_escaper_tb.sv
